/* rtl/core/set_assoc_cache_lookup_core_defines.svh */
// Assertion macros shared by the set-associative cache lookup RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef SET_ASSOC_CACHE_LOOKUP_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SACL_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SACL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sacl_pkg.sv */
// Shared constants and types for the set-associative cache lookup.
// Used by the top level; has no dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int NUM_SETS   = 64;
  localparam int WAYS       = 8;
  localparam int ADDR_BITS  = 64;
  localparam int SET_BITS   = 6;
  localparam int WAY_BITS   = 3;
  localparam int TAG_BITS   = 64;
  localparam int STAMP_BITS = 64;
  localparam int COUNT_BITS = 32;
  localparam int LAT_BITS   = 17;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE        = 3'd0,
    REG_HIT_LATENCY = 3'd1,
    REG_MISS_PEN    = 3'd2,
    REG_OFFSET_BITS = 3'd3,
    REG_INDEX_BITS  = 3'd4,
    REG_WAYS        = 3'd5
  } reg_index_t;

  typedef enum logic {
    MODE_LRU  = 1'b0,
    MODE_FIFO = 1'b1
  } repl_mode_t;

  // One memory row holds every way of one set.
  typedef struct packed {
    logic [WAYS-1:0]                 valid;
    logic [WAYS-1:0][TAG_BITS-1:0]   tag;
    logic [WAYS-1:0][STAMP_BITS-1:0] stamp;
  } row_t;

endpackage

/* rtl/core/set_assoc_cache_lookup_core.sv */
// Top level of the set-associative cache lookup with LRU or FIFO replacement.
// Depends on sacl_pkg, sacl_ram and set_assoc_cache_lookup_core_defines.svh.
`timescale 1ns / 1ps
`include "set_assoc_cache_lookup_core_defines.svh"

// Each accepted address goes through these steps in order: the set row is read from the row memory,
// the ways are compared in parallel, and the updated row is written back once the output register
// is free. On a miss with every way in use valid, a victim search walks the stamps one way per
// cycle between the compare and the write-back. One item is in flight at a time; a finished result
// waits in its output register while the next address is already taken. Valid state is kept in
// one flip-flop per set, so no clearing pass follows reset.
module set_assoc_cache_lookup_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sacl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 addr_valid,
  output logic                                 addr_ready,
  input  logic [sacl_pkg::ADDR_BITS-1:0]       address,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 hit,
  output logic [sacl_pkg::LAT_BITS-1:0]        latency,
  output logic [sacl_pkg::WAY_BITS-1:0]        way_used,
  output logic [sacl_pkg::SET_BITS-1:0]        set_used,
  output logic [sacl_pkg::COUNT_BITS-1:0]      hit_total,
  output logic [sacl_pkg::COUNT_BITS-1:0]      miss_total
);

  import sacl_pkg::*;

  localparam int ROW_BITS = $bits(row_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t state;

  logic       replacement_mode;
  logic [9:0] hit_latency;
  logic [15:0] miss_penalty;
  logic [3:0] offset_bit_count;
  logic [2:0] index_bit_count;
  logic [3:0] ways_in_use;

  logic [TAG_BITS-1:0]   tag_q;
  logic [SET_BITS-1:0]   set_q;
  logic [3:0]            ways_q;
  logic                  hit_q;
  logic [WAY_BITS-1:0]   way_q;
  logic [WAY_BITS-1:0]   scan_way;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [STAMP_BITS-1:0] access_stamp;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] miss_count;
  logic [NUM_SETS-1:0]   row_valid;

  logic [ADDR_BITS-1:0]  addr_shift;
  logic [6:0]            set_mask;
  logic [SET_BITS-1:0]   set_calc;
  logic [TAG_BITS-1:0]   tag_calc;
  logic [3:0]            ways_calc;
  logic                  accept;
  logic                  advance;

  logic [ROW_BITS-1:0]   rd_bits;
  row_t                  rd_row;
  row_t                  wr_row;
  logic [WAYS-1:0]       valid_vec;
  logic [WAYS-1:0]       inuse_vec;
  logic [WAYS-1:0]       hit_vec;
  logic [WAYS-1:0]       free_vec;
  logic                  hit_any;
  logic                  free_any;
  logic [WAY_BITS-1:0]   hit_way;
  logic [WAY_BITS-1:0]   free_way;
  logic [STAMP_BITS-1:0] scan_stamp;
  logic                  scan_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_mode <= MODE_LRU;
      hit_latency      <= 10'd1;
      miss_penalty     <= 16'd100;
      offset_bit_count <= 4'd6;
      index_bit_count  <= 3'd6;
      ways_in_use      <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        replacement_mode <= cfg_data[0];
        REG_HIT_LATENCY: hit_latency      <= cfg_data[9:0];
        REG_MISS_PEN:    miss_penalty     <= cfg_data[15:0];
        REG_OFFSET_BITS: offset_bit_count <= cfg_data[3:0];
        REG_INDEX_BITS:  index_bit_count  <= cfg_data[2:0];
        REG_WAYS:        ways_in_use      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    addr_shift = address >> offset_bit_count;
    set_mask   = 7'((8'd1 << index_bit_count) - 8'd1);
    set_calc   = SET_BITS'(addr_shift[6:0] & set_mask);
    tag_calc   = address >> ({1'b0, offset_bit_count} + {2'b00, index_bit_count});
    if (ways_in_use == 4'd0) begin
      ways_calc = 4'd1;
    end else if (ways_in_use > 4'(WAYS)) begin
      ways_calc = 4'(WAYS);
    end else begin
      ways_calc = ways_in_use;
    end
  end

  assign addr_ready = (state == S_IDLE);
  assign accept     = addr_valid && addr_ready;
  assign advance    = !result_valid || result_ready;

  sacl_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(NUM_SETS)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  ((state == S_WRITE) && advance),
    .wr_addr(set_q),
    .wr_data(wr_row),
    .rd_en  (accept),
    .rd_addr(set_calc),
    .rd_data(rd_bits)
  );

  assign rd_row = row_t'(rd_bits);

  always_comb begin
    valid_vec = row_valid[set_q] ? rd_row.valid : '0;
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      inuse_vec[w] = (4'(w) < ways_q);
      hit_vec[w]   = valid_vec[w] && inuse_vec[w] && (rd_row.tag[w] == tag_q);
      free_vec[w]  = !valid_vec[w] && inuse_vec[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (free_vec[w]) begin
        free_any = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    scan_stamp = rd_row.stamp[scan_way];
    scan_last  = ({1'b0, scan_way} == (ways_q - 4'd1));
  end

  always_comb begin
    wr_row              = rd_row;
    wr_row.valid        = valid_vec;
    wr_row.valid[way_q] = 1'b1;
    if (!hit_q) begin
      wr_row.tag[way_q]   = tag_q;
      wr_row.stamp[way_q] = access_stamp;
    end else if (replacement_mode == MODE_LRU) begin
      wr_row.stamp[way_q] = access_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      access_stamp <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
      row_valid    <= '0;
    end else begin
      if (result_valid && result_ready && (state != S_WRITE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            tag_q        <= tag_calc;
            set_q        <= set_calc;
            ways_q       <= ways_calc;
            access_stamp <= access_stamp + STAMP_BITS'(1);
            state        <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q      <= hit_any;
          scan_way   <= WAY_BITS'(1);
          best_stamp <= rd_row.stamp[0];
          if (hit_any) begin
            way_q <= hit_way;
            state <= S_WRITE;
          end else if (free_any) begin
            way_q <= free_way;
            state <= S_WRITE;
          end else begin
            way_q <= '0;
            state <= (ways_q == 4'd1) ? S_WRITE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_stamp < best_stamp) begin
            best_stamp <= scan_stamp;
            way_q      <= scan_way;
          end
          scan_way <= scan_way + WAY_BITS'(1);
          if (scan_last) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (advance) begin
            row_valid[set_q] <= 1'b1;
            result_valid     <= 1'b1;
            hit              <= hit_q;
            way_used         <= way_q;
            set_used         <= set_q;
            if (hit_q) begin
              latency    <= LAT_BITS'(hit_latency);
              hit_count  <= (&hit_count) ? hit_count : hit_count + COUNT_BITS'(1);
              hit_total  <= (&hit_count) ? hit_count : hit_count + COUNT_BITS'(1);
              miss_total <= miss_count;
            end else begin
              latency    <= LAT_BITS'(hit_latency) + LAT_BITS'(miss_penalty);
              miss_count <= (&miss_count) ? miss_count : miss_count + COUNT_BITS'(1);
              miss_total <= (&miss_count) ? miss_count : miss_count + COUNT_BITS'(1);
              hit_total  <= hit_count;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SACL_ASSERT_SAME(a_result_from_write, clk, rst, result_valid && !$past(result_valid), $past(state == S_WRITE), "result appeared without a row write-back")
  `SACL_ASSERT_SAME(a_scan_in_range, clk, rst, state == S_SCAN, 4'(scan_way) < ways_q, "victim scan ran past the ways in use")
  `SACL_ASSERT_SAME(a_way_in_range, clk, rst, state == S_WRITE, 4'(way_q) < ways_q, "selected way lies outside the ways in use")
  `SACL_ASSERT_NEXT(a_accept_reads, clk, rst, accept, state == S_LOOK, "accepted address did not start a lookup")

endmodule

/* rtl/core/sacl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds its value while no read is issued; no dependencies.
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
